/* rtl/rtt_pkg.sv */
`default_nettype none

package rtt_pkg;

	localparam int TIME_BITS        = 32;
	// divisors are powers of two: the averages reduce to shifts
	localparam int SMOOTH_DIVISOR   = 8;
	localparam int VARIANCE_DIVISOR = 4;
	localparam int SMOOTH_SHIFT     = $clog2(SMOOTH_DIVISOR);
	localparam int VARIANCE_SHIFT   = $clog2(VARIANCE_DIVISOR);

	typedef logic [TIME_BITS-1:0] time_t;

	localparam time_t NO_MIN_RTT = '1;

	typedef struct packed {
		time_t smoothed;
		time_t variance;
		time_t min_rtt;
		time_t latest;
		time_t max_delay;
	} rtt_state_t;

endpackage

`default_nettype wire

/* rtl/rtt_update.sv */
`default_nettype none

module rtt_update
	import rtt_pkg::*;
(
	input  wire time_t      sample,
	input  wire time_t      delay,
	input  wire rtt_state_t cur,
	output rtt_state_t      nxt
);

	time_t                new_min;
	logic                 none_yet;
	logic [TIME_BITS:0]   min_plus_delay;
	logic                 use_delay;
	time_t                lat;
	time_t                diff;
	time_t                var_up;
	time_t                sm_up;

	always_comb begin
		new_min        = (sample < cur.min_rtt) ? sample : cur.min_rtt;
		none_yet       = (cur.min_rtt == NO_MIN_RTT);
		min_plus_delay = {1'b0, new_min} + {1'b0, delay};
		use_delay      = (sample > delay) &&
		                 (({1'b0, sample} > min_plus_delay) || none_yet);
		lat            = use_delay ? (sample - delay) : sample;
		diff           = (cur.smoothed > lat) ? (cur.smoothed - lat) : (lat - cur.smoothed);

		// ceil(v/D) so that v - ceil(v/D) = floor(v*(D-1)/D)
		var_up = (cur.variance >> VARIANCE_SHIFT) +
		         TIME_BITS'(|cur.variance[VARIANCE_SHIFT-1:0]);
		sm_up  = (cur.smoothed >> SMOOTH_SHIFT) +
		         TIME_BITS'(|cur.smoothed[SMOOTH_SHIFT-1:0]);

		nxt.min_rtt   = new_min;
		nxt.max_delay = (delay > cur.max_delay) ? delay : cur.max_delay;
		nxt.latest    = lat;
		if (cur.smoothed == '0) begin
			nxt.smoothed = lat;
			nxt.variance = lat >> 1;
		end else begin
			nxt.smoothed = (cur.smoothed - sm_up) + (lat >> SMOOTH_SHIFT);
			nxt.variance = (cur.variance - var_up) + (diff >> VARIANCE_SHIFT);
		end
	end

endmodule

`default_nettype wire

/* rtl/rtt_estimator.sv */
// Input words pass through the s1 registers into the state registers.
// Throughput: one word per cycle unless out_ready stalls; the estimator
// state doubles as the result register, so the update logic between input
// and state registers sets it. Reset (arst_n low, asynchronous): no words
// held, minimum = all ones, all other estimates zero.
`default_nettype none

module rtt_estimator
	import rtt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire time_t rtt_sample,
	input  wire time_t ack_delay,
	output logic       out_valid,
	input  wire        out_ready,
	output time_t      smoothed_rtt,
	output time_t      rtt_variance,
	output time_t      minimum_rtt,
	output time_t      latest_rtt,
	output time_t      largest_ack_delay
);

	logic       valid_s1;
	time_t      sample_s1;
	time_t      delay_s1;
	logic       advance;
	logic       out_valid_q;
	rtt_state_t state_q;
	rtt_state_t state_nxt;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= rtt_sample;
			delay_s1  <= ack_delay;
		end
	end

	rtt_update u_update (
		.sample (sample_s1),
		.delay  (delay_s1),
		.cur    (state_q),
		.nxt    (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q       <= 1'b0;
			state_q.smoothed  <= '0;
			state_q.variance  <= '0;
			state_q.min_rtt   <= NO_MIN_RTT;
			state_q.latest    <= '0;
			state_q.max_delay <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign smoothed_rtt      = state_q.smoothed;
	assign rtt_variance      = state_q.variance;
	assign minimum_rtt       = state_q.min_rtt;
	assign latest_rtt        = state_q.latest;
	assign largest_ack_delay = state_q.max_delay;

	a_min_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> minimum_rtt <= $past(minimum_rtt))
		else $error("minimum rtt increased");

	a_delay_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> largest_ack_delay >= $past(largest_ack_delay))
		else $error("largest ack delay decreased");

	a_latest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> latest_rtt <= $past(sample_s1))
		else $error("latest rtt exceeds raw sample");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a word");

endmodule

`default_nettype wire

/* tb/rtt_estimator_checker.sv */
`default_nettype none

module rtt_estimator_checker
	import rtt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_ready,
	input  wire time_t rtt_sample,
	input  wire time_t ack_delay,
	input  wire        out_valid,
	input  wire        out_ready,
	input  wire time_t smoothed_rtt,
	input  wire time_t rtt_variance,
	input  wire time_t minimum_rtt,
	input  wire time_t latest_rtt,
	input  wire time_t largest_ack_delay,
	output int         fail_count,
	output int         pending,
	output int         checked
);

	localparam rtt_state_t EST_RESET = '{
		smoothed: '0, variance: '0, min_rtt: NO_MIN_RTT, latest: '0, max_delay: '0
	};

	rtt_state_t est = EST_RESET;
	rtt_state_t want;
	rtt_state_t expected_words[$];
	int         fails = 0;
	int         words_checked = 0;

	// v * (d - 1) / d, rounded down
	function automatic time_t decayed(time_t v, int d);
		time_t share;
		share = v / time_t'(d) + time_t'((v % time_t'(d)) != '0);
		return v - share;
	endfunction

	task automatic fold_in(time_t s, time_t d);
		time_t                sample;
		time_t                new_min;
		time_t                diff;
		logic [TIME_BITS:0]   floor_sum;
		logic                 none_yet;
		logic                 take_delay;
		sample   = s;
		new_min  = (s < est.min_rtt) ? s : est.min_rtt;
		none_yet = (est.min_rtt == NO_MIN_RTT);
		if (d > est.max_delay)
			est.max_delay = d;
		floor_sum  = {1'b0, new_min} + {1'b0, d};
		take_delay = (s > d) && (({1'b0, s} > floor_sum) || none_yet);
		if (take_delay)
			sample = s - d;
		est.min_rtt = new_min;
		est.latest  = sample;
		if (est.smoothed == '0) begin
			est.smoothed = sample;
			est.variance = sample >> 1;
		end else begin
			diff = (est.smoothed > sample) ? est.smoothed - sample : sample - est.smoothed;
			est.variance = decayed(est.variance, VARIANCE_DIVISOR)
				+ diff / time_t'(VARIANCE_DIVISOR);
			est.smoothed = decayed(est.smoothed, SMOOTH_DIVISOR)
				+ sample / time_t'(SMOOTH_DIVISOR);
		end
		expected_words.push_back(est);
	endtask

	task automatic compare_field(string name, time_t exp_val, time_t act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est = EST_RESET;
			expected_words.delete();
			fail_count <= fails;
			pending    <= 0;
			checked    <= words_checked;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with no expectation waiting");
					fails++;
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					compare_field("smoothed_rtt", want.smoothed, smoothed_rtt);
					compare_field("rtt_variance", want.variance, rtt_variance);
					compare_field("minimum_rtt", want.min_rtt, minimum_rtt);
					compare_field("latest_rtt", want.latest, latest_rtt);
					compare_field("largest_ack_delay", want.max_delay, largest_ack_delay);
				end
			end
			if (in_valid && in_ready)
				fold_in(rtt_sample, ack_delay);
			fail_count <= fails;
			pending    <= expected_words.size();
			checked    <= words_checked;
		end
	end

endmodule

`default_nettype wire

/* tb/rtt_estimator_tb.sv */
`default_nettype none

module rtt_estimator_tb;
	import rtt_pkg::*;

	localparam int QUIET_LIMIT     = 2000;
	localparam int WORDS_PER_PHASE = 217;
	localparam int DRAIN_CYCLES    = 10;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	time_t rtt_sample;
	time_t ack_delay;
	logic  out_valid;
	logic  out_ready;
	time_t smoothed_rtt;
	time_t rtt_variance;
	time_t minimum_rtt;
	time_t latest_rtt;
	time_t largest_ack_delay;
	int    fail_count;
	int    pending;
	int    checked;

	int tx_idle = 33;
	int rx_idle = 53;
	int sent = 0;
	int quiet_cycles = 0;

	rtt_estimator dut (.*);

	rtt_estimator_checker checker_i (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk)
		if (arst_n)
			out_ready <= ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("rtt_estimator test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_word(input time_t s, input time_t d);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		rtt_sample <= s;
		ack_delay  <= d;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
	endtask

	function automatic time_t extreme_value();
		case ($urandom_range(3))
			0: return '0;
			1: return 1;
			2: return NO_MIN_RTT - 1;
			default: return NO_MIN_RTT;
		endcase
	endfunction

	// phase 0: realistic traffic only; later: noise and extremes, phase 2 tiny samples too
	task automatic pick_word(input int phase, input time_t base,
			output time_t s, output time_t d);
		int pick;
		pick = $urandom_range(99);
		if (phase >= 1 && pick < 15) begin
			s = $urandom;
			d = $urandom;
		end else if (phase >= 1 && pick < 20) begin
			s = extreme_value();
			d = extreme_value();
		end else if (phase == 2 && pick < 30) begin
			s = $urandom_range(15);
			d = $urandom_range(7);
		end else begin
			s = base + $urandom_range(base);
			if ($urandom_range(7) == 0)
				d = s - $urandom_range(600);
			else
				d = $urandom_range(2 * base);
		end
	endtask

	initial begin
		time_t s;
		time_t d;
		time_t base;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		out_ready  = 1'b0;
		rtt_sample = '0;
		ack_delay  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// all-ones samples keep "no minimum"; the delay then always applies
		send_word(NO_MIN_RTT, NO_MIN_RTT - 1);
		// latest of 3 pulls smoothed from 1 down to 0
		send_word(NO_MIN_RTT, NO_MIN_RTT - 3);
		// smoothed is zero again: re-seeded
		send_word(NO_MIN_RTT, NO_MIN_RTT - 2);
		send_word(NO_MIN_RTT, NO_MIN_RTT);
		send_word(1000, 200);
		send_word(1500, 400);
		send_word(1400, 400);
		send_word(300, 300);
		send_word(1000, 0);
		send_word(301, 1);
		send_word(600, 300);
		send_word(601, 300);
		// min plus delay overflows 32 bits
		send_word(NO_MIN_RTT, 32'hFFFF_FF00);
		send_word(NO_MIN_RTT - 1, 0);
		send_word(32'hAAAA_AAAA, 32'h5555_5555);
		send_word(32'h5555_5555, 32'hAAAA_AAAA);
		send_word(1, 0);
		send_word(5000, NO_MIN_RTT - 1);
		send_word(299, 0);
		send_word(20000, 19000);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin tx_idle = 33; rx_idle = 53; end
				1: begin tx_idle = 53; rx_idle = 33; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			base = $urandom_range(400000, 100000);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				pick_word(phase, base, s, d);
				send_word(s, d);
			end
		end
		@(negedge clk) in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d sample words sent, %0d result words checked", sent, checked);
		$display("covered: no-minimum and decay-to-zero cases, wide min+delay, noisy traffic");
		if (fail_count == 0 && pending == 0)
			$display("rtt_estimator test passed");
		else
			$display("rtt_estimator test failed");
		$finish;
	end

endmodule

`default_nettype wire
